[rtl/qsal_pkg.sv]
// ----------------------------------------------------------------------------
// qsal_pkg
// Shared types, constants and arithmetic helpers for the quintic spline
// arc length core.
// ----------------------------------------------------------------------------
package qsal_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = 11;   // sample count / index width
    localparam int COEF_W      = 48;   // Q16.32 coefficients
    localparam int KNOT_W      = 32;   // Q8.24 knot length
    localparam int SUM_W       = 48;   // Q16.32 running length
    localparam int H_W         = 63;   // Horner accumulator, |h| <= 2^61
    localparam int DVD_W       = 64;   // divider dividend / quotient
    localparam int DVS_W       = 49;   // divider divisor
    localparam int BITS_W      = 7;    // divider step count, up to 64
    localparam int CFG_IDX_W   = 3;

    localparam logic [H_W-1:0]   CLAMP_LIM = H_W'(1) << 61;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [16:0]      T_ONE     = 17'h10000;

    // dividend significant bits for each division
    localparam logic [BITS_W-1:0] XDIV_BITS = 7'd43;
    localparam logic [BITS_W-1:0] TDIV_BITS = 7'd57;
    localparam logic [BITS_W-1:0] FDIV_BITS = 7'd64;
    localparam logic [BITS_W-1:0] PDIV_BITS = 7'd26;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF_A  = 3'd0,
        CFG_COEFF_B  = 3'd1,
        CFG_COEFF_C  = 3'd2,
        CFG_COEFF_D  = 3'd3,
        CFG_COEFF_E  = 3'd4,
        CFG_KNOT     = 3'd5,
        CFG_SAMPLES  = 3'd6
    } t_cfg_idx;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_XMUL,
        OP_XDIV,
        OP_XCAP,
        OP_HMUL,
        OP_HADD,
        OP_SQ,
        OP_SQRT,
        OP_FCAP,
        OP_TMUL,
        OP_TDIV,
        OP_ACC,
        OP_ADV,
        OP_FDIV,
        OP_PDIV,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic   ready;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic first;
        logic h_last;
        logic found;
        logic last;
        logic out_full;
    } t_dp_sts;

    // coefficient scaled by its derivative weight
    function automatic logic signed [63:0] coef_term(input logic signed [COEF_W-1:0] c,
                                                     input logic [2:0] w);
        logic signed [63:0] e;
        e = 64'(c);
        case (w)
            3'd5:    coef_term = (e <<< 2) + e;
            3'd4:    coef_term = e <<< 2;
            3'd3:    coef_term = (e <<< 1) + e;
            3'd2:    coef_term = e <<< 1;
            default: coef_term = e;
        endcase
    endfunction

    // clamp to +-2^61
    function automatic logic signed [H_W-1:0] clamp_h(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = $signed({1'b0, CLAMP_LIM});
        if (v > lim) begin
            clamp_h = $signed(CLAMP_LIM);
        end else if (v < -lim) begin
            clamp_h = -$signed(CLAMP_LIM);
        end else begin
            clamp_h = v[H_W-1:0];
        end
    endfunction

endpackage

[rtl/qsal_div.sv]
// ----------------------------------------------------------------------------
// qsal_div
// Restoring divider, one quotient bit per cycle, variable step count.
// ----------------------------------------------------------------------------
module qsal_div
    import qsal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [DVS_W-1:0]     i_divisor,
    input  logic [BITS_W-1:0]    i_bits,
    output logic                 o_busy,
    output logic [DVD_W-1:0]     o_quotient
);

    logic [BITS_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;

    logic [DVS_W:0]    rem_s;
    logic              ge;
    logic [DVS_W:0]    diff;

    // trial subtract
    assign rem_s = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = rem_s >= {1'b0, r_dvs};
    assign diff  = rem_s - {1'b0, r_dvs};

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_bits;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend << (7'd64 - i_bits);
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? diff[DVS_W-1:0] : rem_s[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

[rtl/qsal_datapath.sv]
// ----------------------------------------------------------------------------
// qsal_datapath
// Config registers, Horner evaluation, square root, trapezoid accumulation,
// interpolation and the output register.
// ----------------------------------------------------------------------------
module qsal_datapath
    import qsal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    // config
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COEF_W-1:0]     i_cfg_data,
    // input item
    input  logic                  i_in_valid,
    input  logic                  i_action,
    input  logic [31:0]           i_target,
    // result item
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_total_len,
    output logic [16:0]           o_param_t
);

    // configuration
    logic signed [COEF_W-1:0] r_coef [5];
    logic [KNOT_W-1:0]        r_knot;
    logic [CNT_W-1:0]         r_nsamp;

    // request state
    logic                     r_locate;
    logic [31:0]              r_target;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_idx;
    logic [1:0]               r_hk;
    logic                     r_found;

    // sample pipeline
    logic [42:0]              r_px;
    logic [31:0]              r_x;
    logic signed [H_W-1:0]    r_h;
    logic [61:0]              r_hp;
    logic [63:0]              r_lo;
    logic                     r_neg;
    logic                     r_sat;
    logic [63:0]              r_sq;
    logic [31:0]              r_f;
    logic [31:0]              r_pf;
    logic [63:0]              r_tprod;
    logic                     r_shi;
    logic [SUM_W-1:0]         r_rs;
    logic [SUM_W-1:0]         r_ps;

    // square root
    logic [63:0]              r_v;
    logic [63:0]              r_res;
    logic [63:0]              r_bit;
    logic [5:0]               r_scnt;

    // output register
    logic                     r_ov;
    logic [31:0]              r_arc;
    logic [16:0]              r_t;

    // divider hookup
    logic                     div_start;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic [BITS_W-1:0]        div_bits;
    logic                     div_busy;
    logic [DVD_W-1:0]         quo;

    logic                     accept;
    logic [61:0]              h_mag;
    logic                     big;
    logic [61:0]              mx_r;
    logic [61:0]              mx_c;
    logic signed [63:0]       mx_s;
    logic signed [63:0]       h_sum;
    logic [2:0]               coef_sel;
    logic [2:0]               coef_w;
    logic [32:0]              f_sum;
    logic [31:0]              f_val;
    logic [58:0]              acc_sum;
    logic [SUM_W-1:0]         acc_new;
    logic [SUM_W-1:0]         tgt48;
    logic [63:0]              sq_try;
    logic [CNT_W-1:0]         n_eff;

    assign accept = i_in_valid && i_cmd.ready;
    assign tgt48  = {r_target, 16'b0};

    // clamp sample count into 1..MAX_SAMPLES
    always_comb begin
        if (r_nsamp == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_nsamp > CNT_W'(MAX_SAMPLES)) begin
            n_eff = CNT_W'(MAX_SAMPLES);
        end else begin
            n_eff = r_nsamp;
        end
    end

    // magnitude of Horner value
    assign h_mag = r_h[H_W-1] ? 62'(-r_h) : 62'(r_h);

    // h times x recombined, truncated toward zero, clamped
    assign big  = |r_hp[61:53];
    assign mx_r = {r_hp[52:0], 8'b0} + 62'(r_lo[63:24]);
    assign mx_c = (big || mx_r > 62'(CLAMP_LIM)) ? 62'(CLAMP_LIM) : mx_r;
    assign mx_s = r_neg ? -$signed({2'b0, mx_c}) : $signed({2'b0, mx_c});

    assign coef_sel = 3'(r_hk) + 3'd1;
    assign coef_w   = 3'd4 - 3'(r_hk);
    assign h_sum    = mx_s + coef_term(r_coef[coef_sel], coef_w);

    // integrand and trapezoid sum
    assign f_val   = r_sat ? 32'hFFFF_FFFF : r_res[31:0];
    assign f_sum   = {1'b0, r_pf} + {1'b0, r_f};
    assign acc_sum = {11'b0, r_rs} + quo[58:0];
    assign acc_new = (acc_sum > 59'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];
    assign sq_try  = r_res + r_bit;

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = DVS_W'(r_n);
        div_bits  = XDIV_BITS;
        case (i_cmd.op)
            OP_XDIV: begin
                div_start = 1'b1;
                div_dvd   = 64'(r_px);
            end
            OP_TDIV: begin
                div_start = 1'b1;
                div_dvd   = {8'b0, r_tprod[63:8]}
                          + (r_shi ? {8'b0, r_knot, 24'b0} : 64'b0);
                div_dvs   = DVS_W'({r_n, 1'b0});
                div_bits  = TDIV_BITS;
            end
            OP_FDIV: begin
                div_start = 1'b1;
                div_dvd   = {tgt48 - r_ps, 16'b0};
                div_dvs   = DVS_W'(r_rs - r_ps);
                div_bits  = FDIV_BITS;
            end
            OP_PDIV: begin
                div_start = 1'b1;
                div_dvd   = 64'({r_idx - 1'b1, 16'b0}) + 64'(quo[15:0]);
                div_bits  = PDIV_BITS;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    qsal_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_bits     (div_bits),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_coef[k] <= '0;
            end
            r_knot  <= 32'h0100_0000;
            r_nsamp <= CNT_W'(100);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEFF_A: r_coef[0] <= i_cfg_data;
                CFG_COEFF_B: r_coef[1] <= i_cfg_data;
                CFG_COEFF_C: r_coef[2] <= i_cfg_data;
                CFG_COEFF_D: r_coef[3] <= i_cfg_data;
                CFG_COEFF_E: r_coef[4] <= i_cfg_data;
                CFG_KNOT:    r_knot    <= i_cfg_data[KNOT_W-1:0];
                CFG_SAMPLES: r_nsamp   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // request control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_hk    <= '0;
            r_found <= 1'b0;
            r_scnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            case (i_cmd.op)
                OP_XCAP: r_hk <= '0;
                OP_HADD: r_hk <= r_hk + 1'b1;
                OP_SQRT: r_scnt <= 6'd32;
                OP_FCAP: begin
                    if (r_idx == '0) begin
                        r_idx <= CNT_W'(1);
                    end
                end
                OP_ACC:  r_found <= r_locate && (acc_new > tgt48);
                OP_ADV: begin
                    if (!r_found && r_idx != r_n) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                OP_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (r_scnt != '0) begin
                r_scnt <= r_scnt - 1'b1;
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_locate <= i_action;
            r_target <= i_target;
            r_n      <= n_eff;
            r_rs     <= '0;
            r_ps     <= '0;
        end
        case (i_cmd.op)
            OP_XMUL: r_px <= 43'(r_knot) * 43'(r_idx);
            OP_XCAP: begin
                r_x <= quo[31:0];
                r_h <= H_W'(coef_term(r_coef[0], 3'd5));
            end
            OP_HMUL: begin
                r_neg <= r_h[H_W-1];
                r_hp  <= 62'(h_mag[61:32]) * 62'(r_x);
                r_lo  <= 64'(h_mag[31:0]) * 64'(r_x);
            end
            OP_HADD: r_h <= clamp_h(h_sum);
            OP_SQ: begin
                r_sat <= |h_mag[61:48];
                r_sq  <= 64'(h_mag[47:16]) * 64'(h_mag[47:16]);
            end
            OP_FCAP: begin
                if (r_idx == '0) begin
                    r_pf <= f_val;
                end else begin
                    r_f <= f_val;
                end
            end
            OP_TMUL: begin
                r_tprod <= 64'(r_knot) * 64'(f_sum[31:0]);
                r_shi   <= f_sum[32];
            end
            OP_ACC: begin
                r_ps <= r_rs;
                r_rs <= acc_new;
            end
            OP_ADV: begin
                if (!r_found && r_idx != r_n) begin
                    r_pf <= r_f;
                end
            end
            OP_OUT: begin
                if (!r_ov) begin
                    r_arc <= r_locate ? 32'b0 : r_rs[SUM_W-1:16];
                    r_t   <= r_found ? quo[16:0] : T_ONE;
                end
            end
            default: ;
        endcase
    end

    // square root, one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SQRT) begin
            r_v   <= r_sq + 64'h1_0000_0000;
            r_res <= '0;
            r_bit <= 64'(1) << 62;
        end else if (r_scnt != '0) begin
            if (r_v >= sq_try) begin
                r_v   <= r_v - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // status to controller
    assign o_sts.div_busy  = div_busy;
    assign o_sts.sqrt_busy = r_scnt != '0;
    assign o_sts.first     = r_idx == '0;
    assign o_sts.h_last    = r_hk == 2'd3;
    assign o_sts.found     = r_found;
    assign o_sts.last      = r_idx == r_n;
    assign o_sts.out_full  = r_ov;

    assign o_out_valid = r_ov;
    assign o_total_len = r_arc;
    assign o_param_t   = r_t;

endmodule

[rtl/qsal_ctrl.sv]
// ----------------------------------------------------------------------------
// qsal_ctrl
// Sequencer: walks each sample through x, Horner, root and trapezoid steps.
// ----------------------------------------------------------------------------
module qsal_ctrl
    import qsal_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_XMUL, S_XDIV, S_XWAIT, S_XCAP, S_HMUL, S_HADD, S_SQ,
        S_SQRT, S_SWAIT, S_FCAP, S_TMUL, S_TDIV, S_TWAIT, S_ACC, S_CHECK,
        S_FDIV, S_FWAIT, S_PDIV, S_PWAIT, S_DONE
    } t_state;

    t_state  r_state;
    t_dp_cmd r_cmd;

    // state and registered command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd.ready <= 1'b1;
            r_cmd.op    <= OP_NONE;
        end else begin
            r_cmd.ready <= 1'b0;
            r_cmd.op    <= OP_NONE;
            case (r_state)
                S_IDLE: begin
                    r_cmd.ready <= 1'b1;
                    if (i_in_valid) begin
                        r_cmd.ready <= 1'b0;
                        r_cmd.op    <= OP_XMUL;
                        r_state     <= S_XMUL;
                    end
                end
                S_XMUL: begin
                    r_cmd.op <= OP_XDIV;
                    r_state  <= S_XDIV;
                end
                S_XDIV: r_state <= S_XWAIT;
                S_XWAIT: begin
                    if (!i_sts.div_busy) begin
                        r_cmd.op <= OP_XCAP;
                        r_state  <= S_XCAP;
                    end
                end
                S_XCAP: begin
                    r_cmd.op <= OP_HMUL;
                    r_state  <= S_HMUL;
                end
                S_HMUL: begin
                    r_cmd.op <= OP_HADD;
                    r_state  <= S_HADD;
                end
                S_HADD: begin
                    if (i_sts.h_last) begin
                        r_cmd.op <= OP_SQ;
                        r_state  <= S_SQ;
                    end else begin
                        r_cmd.op <= OP_HMUL;
                        r_state  <= S_HMUL;
                    end
                end
                S_SQ: begin
                    r_cmd.op <= OP_SQRT;
                    r_state  <= S_SQRT;
                end
                S_SQRT: r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (!i_sts.sqrt_busy) begin
                        r_cmd.op <= OP_FCAP;
                        r_state  <= S_FCAP;
                    end
                end
                // sample zero only seeds the previous integrand
                S_FCAP: begin
                    if (i_sts.first) begin
                        r_cmd.op <= OP_XMUL;
                        r_state  <= S_XMUL;
                    end else begin
                        r_cmd.op <= OP_TMUL;
                        r_state  <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_cmd.op <= OP_TDIV;
                    r_state  <= S_TDIV;
                end
                S_TDIV: r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (!i_sts.div_busy) begin
                        r_cmd.op <= OP_ACC;
                        r_state  <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_cmd.op <= OP_ADV;
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_sts.found) begin
                        r_cmd.op <= OP_FDIV;
                        r_state  <= S_FDIV;
                    end else if (i_sts.last) begin
                        r_cmd.op <= OP_OUT;
                        r_state  <= S_DONE;
                    end else begin
                        r_cmd.op <= OP_XMUL;
                        r_state  <= S_XMUL;
                    end
                end
                S_FDIV: r_state <= S_FWAIT;
                S_FWAIT: begin
                    if (!i_sts.div_busy) begin
                        r_cmd.op <= OP_PDIV;
                        r_state  <= S_PDIV;
                    end
                end
                S_PDIV: r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (!i_sts.div_busy) begin
                        r_cmd.op <= OP_OUT;
                        r_state  <= S_DONE;
                    end
                end
                // hold until the output register is free
                S_DONE: begin
                    if (!i_sts.out_full) begin
                        r_cmd.ready <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_cmd.op <= OP_OUT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd = r_cmd;

endmodule

[rtl/quintic_spline_arc_length_core.sv]
// ----------------------------------------------------------------------------
// quintic_spline_arc_length_core
// Trapezoid-rule arc length of a quintic segment, measure or locate.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (i_cfg_*): index 0..4 coefficients a..e, 5 knot length,
//   6 sample count N; other indexes are ignored. Always ready; write only
//   while no request is in flight.
//   Input stream (s_axis_*): tuser = action (0 measure, 1 locate),
//   tdata = target distance. One request is worked on at a time; tready is
//   high only while the sequencer is idle.
//   Output stream (m_axis_*): one item per request, held in an output
//   register, so the next request is taken while a result waits.
// Sample cost: set by the shared bit-serial divider (43 steps for x, 57 for
//   the trapezoid) and the 32-step square root. Locate adds the two
//   interpolation divides.
// Reset: synchronous active low; registers return to a=..=e=0, knot 1.0,
//   N=100, and the output holds no item. A stalled receiver only stops the
//   sequencer at the end of a request, before writing the output register.
// ----------------------------------------------------------------------------
module quintic_spline_arc_length_core
    import qsal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] target_distance
    input  logic                 s_axis_tuser,   // [0] action
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata    // [31:0] total length, [48:32] param_t
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] arc;
    logic [16:0] pt;

    qsal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qsal_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_action     (s_axis_tuser),
        .i_target     (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_total_len  (arc),
        .o_param_t    (pt)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = cmd.ready;
    assign m_axis_tdata  = {7'b0, pt, arc};

endmodule
